// ===== hw/rtl/dlcst_pkg.sv =====
// Package for the deck line comment and slash trim filter.
// Holds byte codes, command types and sizing defaults shared by all modules.
// No dependencies.
package dlcst_pkg;

   localparam logic [7:0] NL_BYTE     = 8'd10;
   localparam logic [7:0] DASH_BYTE   = 8'd45;
   localparam logic [7:0] SLASH_BYTE  = 8'd47;
   localparam logic [7:0] SQUOTE_BYTE = 8'd39;
   localparam logic [7:0] DQUOTE_BYTE = 8'd34;

   localparam int MAX_PENDING_DEF = 32;
   localparam int QUEUE_DEPTH_DEF = 4;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_HOLD,
      OP_TEXT,
      OP_NEWLINE,
      OP_DROP
   } dlcst_op_type;

   typedef struct packed {
      logic         dash;
      dlcst_op_type op;
      logic [7:0]   data;
   } dlcst_cmd_type;

   typedef struct packed {
      logic          valid;
      dlcst_cmd_type cmd;
   } dlcst_head_type;

   typedef enum logic {
      BK_DASH,
      BK_OP
   } dlcst_phase_type;

   function automatic logic is_sep(input logic [7:0] b);
      return b inside {8'd32, 8'd9, 8'd13, 8'd11, 8'd12};
   endfunction

endpackage

// ===== hw/rtl/dlcst_front.sv =====
// Front end: classifies each text byte and tracks quote, comment and dash state.
// Produces one command per byte that needs work in the back end. Uses dlcst_pkg.
module dlcst_front import dlcst_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    in_byte,
   output logic          push,
   output dlcst_cmd_type cmd
);

   logic in_quote_ff, in_quote_in;
   logic quote_is_double_ff, quote_is_double_in;
   logic discard_rest_ff, discard_rest_in;
   logic text_started_ff, text_started_in;
   logic dash_pending_ff, dash_pending_in;

   always_comb begin
      logic handled;
      logic ts;
      handled            = 1'b0;
      ts                 = text_started_ff;
      cmd.dash           = 1'b0;
      cmd.op             = OP_NONE;
      cmd.data           = in_byte;
      in_quote_in        = in_quote_ff;
      quote_is_double_in = quote_is_double_ff;
      discard_rest_in    = discard_rest_ff;
      dash_pending_in    = dash_pending_ff;
      if (in_byte == NL_BYTE) begin
         cmd.dash           = dash_pending_ff;
         cmd.op             = OP_NEWLINE;
         in_quote_in        = 1'b0;
         quote_is_double_in = 1'b0;
         discard_rest_in    = 1'b0;
         dash_pending_in    = 1'b0;
      end else if (!discard_rest_ff) begin
         if (dash_pending_ff) begin
            dash_pending_in = 1'b0;
            if (in_byte == DASH_BYTE) begin
               discard_rest_in = 1'b1;
               cmd.op          = OP_DROP;
               handled         = 1'b1;
            end else begin
               cmd.dash = 1'b1;
               ts       = 1'b1;
            end
         end
         if (!handled) begin
            if (in_quote_ff) begin
               if (in_byte == (quote_is_double_ff ? DQUOTE_BYTE : SQUOTE_BYTE)) begin
                  in_quote_in = 1'b0;
               end
               cmd.op = is_sep(in_byte) ? (ts ? OP_HOLD : OP_NONE) : OP_TEXT;
            end else if (in_byte == DASH_BYTE) begin
               dash_pending_in = 1'b1;
            end else if (in_byte == SLASH_BYTE) begin
               cmd.op          = OP_TEXT;
               discard_rest_in = 1'b1;
            end else begin
               if (in_byte == SQUOTE_BYTE || in_byte == DQUOTE_BYTE) begin
                  in_quote_in        = 1'b1;
                  quote_is_double_in = (in_byte == DQUOTE_BYTE);
               end
               cmd.op = is_sep(in_byte) ? (ts ? OP_HOLD : OP_NONE) : OP_TEXT;
            end
         end
      end
      text_started_in = (in_byte == NL_BYTE) ? 1'b0 : (ts || cmd.op == OP_TEXT);
   end

   assign push = accept && (cmd.dash || cmd.op != OP_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quote_ff        <= 1'b0;
         quote_is_double_ff <= 1'b0;
         discard_rest_ff    <= 1'b0;
         text_started_ff    <= 1'b0;
         dash_pending_ff    <= 1'b0;
      end else if (accept) begin
         in_quote_ff        <= in_quote_in;
         quote_is_double_ff <= quote_is_double_in;
         discard_rest_ff    <= discard_rest_in;
         text_started_ff    <= text_started_in;
         dash_pending_ff    <= dash_pending_in;
      end
   end

endmodule

// ===== hw/rtl/dlcst_queue.sv =====
// Command queue between front end and back end.
// Small register FIFO of dlcst_cmd_type entries. Uses dlcst_pkg.
module dlcst_queue import dlcst_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  dlcst_cmd_type  push_cmd,
   output logic           full,
   input  logic           pop,
   output dlcst_head_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   dlcst_cmd_type  slot_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign full      = (count_ff == NW'(DEPTH));
   assign do_push   = push && !full;
   assign do_pop    = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/dlcst_back.sv =====
// Back end: carries out commands, holds the separator buffer and drives results.
// Owns the separator memory and the output register. Uses dlcst_pkg.
module dlcst_back import dlcst_pkg::*; #(
   parameter int MAX_PENDING = MAX_PENDING_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  dlcst_head_type head,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_last,
   output logic           rsp_overflow
);

   localparam int CW = $clog2(MAX_PENDING + 1);
   localparam int AW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;

   logic [7:0]      sep_mem [MAX_PENDING];
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]   idx_ff, idx_in;
   dlcst_phase_type phase_ff, phase_in;

   logic            s1_valid_ff, s1_valid_in;
   logic            s1_mem_ff;
   logic [7:0]      s1_byte_ff;
   logic            s1_last_ff;
   logic            s1_ovf_ff;
   logic [7:0]      rd_ff;

   logic            s1_free, go, have, dash_now;
   logic            emit, e_mem, e_last, e_ovf;
   logic [7:0]      e_byte;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;

   assign s1_free  = !s1_valid_ff || !rsp_stall;
   assign go       = head.valid && s1_free;
   assign have     = (idx_ff < cnt_ff);
   assign dash_now = (phase_ff == BK_DASH) && head.cmd.dash;

   always_comb begin
      emit    = 1'b0;
      e_mem   = 1'b0;
      e_last  = 1'b0;
      e_ovf   = 1'b0;
      e_byte  = head.cmd.data;
      pop     = 1'b0;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      wr_en   = 1'b0;
      wr_addr = cnt_ff[AW-1:0];
      if (go) begin
         if (dash_now) begin
            emit = 1'b1;
            if (have) begin
               e_mem  = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else begin
               e_byte = DASH_BYTE;
               e_last = !(head.cmd.op == OP_TEXT || head.cmd.op == OP_NEWLINE);
               cnt_in = '0;
               idx_in = '0;
               if (e_last) begin
                  pop = 1'b1;
                  if (head.cmd.op == OP_HOLD) begin
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     cnt_in  = CW'(1);
                  end
               end
            end
         end else begin
            case (head.cmd.op)
               OP_TEXT: begin
                  emit = 1'b1;
                  if (have) begin
                     e_mem  = 1'b1;
                     idx_in = idx_ff + 1'b1;
                  end else begin
                     e_last = 1'b1;
                     cnt_in = '0;
                     idx_in = '0;
                     pop    = 1'b1;
                  end
               end
               OP_NEWLINE: begin
                  emit   = 1'b1;
                  e_byte = NL_BYTE;
                  e_last = 1'b1;
                  cnt_in = '0;
                  idx_in = '0;
                  pop    = 1'b1;
               end
               OP_DROP: begin
                  cnt_in = '0;
                  idx_in = '0;
                  pop    = 1'b1;
               end
               OP_HOLD: begin
                  if (cnt_ff == CW'(MAX_PENDING)) begin
                     emit   = 1'b1;
                     e_mem  = 1'b1;
                     e_ovf  = 1'b1;
                     e_last = (idx_ff == CW'(MAX_PENDING - 1));
                     if (e_last) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        cnt_in  = CW'(1);
                        idx_in  = '0;
                        pop     = 1'b1;
                     end else begin
                        idx_in = idx_ff + 1'b1;
                     end
                  end else begin
                     wr_en  = 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                     pop    = 1'b1;
                  end
               end
               default: begin
                  pop = 1'b1;
               end
            endcase
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (pop) begin
         phase_in = BK_DASH;
      end else if (go && dash_now && !have) begin
         phase_in = BK_OP;
      end
   end

   assign s1_valid_in = s1_free ? emit : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         idx_ff      <= '0;
         phase_ff    <= BK_DASH;
         s1_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         idx_ff      <= idx_in;
         phase_ff    <= phase_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && emit) begin
         s1_mem_ff  <= e_mem;
         s1_byte_ff <= e_byte;
         s1_last_ff <= e_last;
         s1_ovf_ff  <= e_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (go && e_mem) begin
         rd_ff <= sep_mem[idx_ff[AW-1:0]];
      end
      if (wr_en) begin
         sep_mem[wr_addr] <= head.cmd.data;
      end
   end

   assign rsp_valid    = s1_valid_ff;
   assign rsp_out_byte = s1_mem_ff ? rd_ff : s1_byte_ff;
   assign rsp_last     = s1_last_ff;
   assign rsp_overflow = s1_ovf_ff;

endmodule

// ===== hw/rtl/deck_line_comment_slash_trim_filter.sv =====
// Top level of the deck line comment and slash trim filter.
// Connects dlcst_front, dlcst_queue and dlcst_back. Uses dlcst_pkg.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_in_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_out_byte, rsp_last, rsp_overflow
//
// One byte is accepted per cycle while the command queue has room.
// The back end produces one result at a time and holds a command at the queue
// head until all of its results, if any, have been produced; a byte causes at
// most MAX_PENDING + 2 results.
// When the queue is empty, a byte's command is written into a queue slot and its
// first result is then registered in the output register.
// Reset is synchronous and clears all control state; the separator memory is not cleared.
// rsp_stall holds the output register; the queue absorbs QUEUE_DEPTH commands
// before req_stall rises.
module deck_line_comment_slash_trim_filter import dlcst_pkg::*; #(
   parameter int MAX_PENDING = MAX_PENDING_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic       rsp_overflow
);

   logic           accept;
   logic           push;
   logic           full;
   logic           pop;
   dlcst_cmd_type  cmd;
   dlcst_head_type head;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   dlcst_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .push    (push),
      .cmd     (cmd)
   );

   dlcst_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (cmd),
      .full     (full),
      .pop      (pop),
      .head     (head)
   );

   dlcst_back #(
      .MAX_PENDING (MAX_PENDING)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_overflow (rsp_overflow)
   );

endmodule

// ===== hw/rtl/dlcst_checker.sv =====
// Port-level checker for the deck line comment and slash trim filter.
// Bound to the top level below. Uses dlcst_pkg.
module dlcst_checker import dlcst_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last,
   input logic       rsp_overflow
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_in_byte))
      else $error("stalled request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last) && $stable(rsp_overflow))
      else $error("stalled transfer changed");

   a_ovf_sep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_out_byte == 8'd32 || rsp_out_byte == 8'd9
         || rsp_out_byte == 8'd13 || rsp_out_byte == 8'd11 || rsp_out_byte == 8'd12)
      else $error("overflow flag on a non-separator byte");

   a_nl_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_byte == NL_BYTE && !rsp_overflow |-> rsp_last)
      else $error("newline not marked last");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind deck_line_comment_slash_trim_filter dlcst_checker u_dlcst_checker (.*);
